[src/rvs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvs_pkg
// Shared widths, codes and types for the ride vibration statistics unit.
// ----------------------------------------------------------------------------
package rvs_pkg;

    // Sample counters saturate at 2^COUNT_BITS - 1
    localparam int COUNT_BITS = 20;
    localparam int CNT_W      = COUNT_BITS;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Item field widths
    localparam int OP_W    = 2;
    localparam int TIME_W  = 32;
    localparam int ACC_W   = 16;
    localparam int NOISE_W = 11;
    localparam int TEMP_W  = 12;
    localparam int HUMI_W  = 11;
    localparam int THR_W   = 16;

    // Running sums
    localparam int NOISE_SUM_W = NOISE_W + CNT_W;
    localparam int HUMI_SUM_W  = HUMI_W + CNT_W;
    localparam int TEMP_SUM_W  = TEMP_W + CNT_W + 1;
    localparam int MAG_W       = (TEMP_SUM_W > NOISE_SUM_W) ?
                                 ((TEMP_SUM_W > HUMI_SUM_W) ? TEMP_SUM_W : HUMI_SUM_W) :
                                 ((NOISE_SUM_W > HUMI_SUM_W) ? NOISE_SUM_W : HUMI_SUM_W);

    // Rounding divider: (2*sum + n) / (2*n)
    localparam int DIV_NUM_W = MAG_W + 1;
    localparam int DIV_DEN_W = CNT_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_THRESHOLD    = 2'd0;
    localparam t_cfg_idx CFG_DEFAULT_TEMP = 2'd1;
    localparam t_cfg_idx CFG_DEFAULT_HUMI = 2'd2;

    localparam logic [THR_W-1:0]         THRESHOLD_RESET    = 16'd128;
    localparam logic signed [TEMP_W-1:0] DEFAULT_TEMP_RESET = 12'sd400;
    localparam logic [HUMI_W-1:0]        DEFAULT_HUMI_RESET = 11'd800;

    // Operation codes
    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_SAMPLE = 2'd0;
    localparam t_op OP_START  = 2'd1;
    localparam t_op OP_STOP   = 2'd2;

    typedef enum logic [1:0] {
        DIV_NOISE,
        DIV_TEMP,
        DIV_HUMI
    } t_div_sel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_REPORT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic     capture;
        logic     apply;
        logic     div_start;
        t_div_sel div_sel;
        logic     save_quo;
        logic     load_out;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic div_done;
    } t_dp_stat;

endpackage

[src/rvs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvs_in_if / rvs_out_if
// Valid/ready channels for input items and report items.
// ----------------------------------------------------------------------------
interface rvs_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [rvs_pkg::OP_W-1:0]             operation;
    logic [rvs_pkg::TIME_W-1:0]           time_ms;
    logic signed [rvs_pkg::ACC_W-1:0]     accel_vertical;
    logic                                 noise_valid;
    logic [rvs_pkg::NOISE_W-1:0]          noise_level;
    logic signed [rvs_pkg::TEMP_W-1:0]    temperature;
    logic [rvs_pkg::HUMI_W-1:0]           humidity;

    modport source (
        output valid, operation, time_ms, accel_vertical, noise_valid,
               noise_level, temperature, humidity,
        input  ready
    );
    modport sink (
        input  valid, operation, time_ms, accel_vertical, noise_valid,
               noise_level, temperature, humidity,
        output ready
    );
endinterface

interface rvs_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [rvs_pkg::ACC_W-1:0]            peak_deviation;
    logic [rvs_pkg::ACC_W-1:0]            peak_jerk;
    logic [rvs_pkg::TIME_W-1:0]           longest_shock_ms;
    logic [rvs_pkg::NOISE_W-1:0]          mean_noise;
    logic signed [rvs_pkg::TEMP_W-1:0]    mean_temperature;
    logic [rvs_pkg::HUMI_W-1:0]           mean_humidity;

    modport source (
        output valid, peak_deviation, peak_jerk, longest_shock_ms, mean_noise,
               mean_temperature, mean_humidity,
        input  ready
    );
    modport sink (
        input  valid, peak_deviation, peak_jerk, longest_shock_ms, mean_noise,
               mean_temperature, mean_humidity,
        output ready
    );
endinterface

[src/rvs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rvs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rvs_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [rvs_pkg::DIV_DEN_W-1:0] i_den,
    output logic                          o_done,
    output logic [rvs_pkg::DIV_NUM_W-1:0] o_quo
);

    localparam int NW = rvs_pkg::DIV_NUM_W;
    localparam int DW = rvs_pkg::DIV_DEN_W;
    localparam int CW = rvs_pkg::DIV_CNT_W;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_den, n_den;
    logic [NW-1:0] r_quo, n_quo;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_quo[NW-1]};
    assign fits  = (trial >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(NW);
            n_rem  = '0;
            n_den  = i_den;
            n_quo  = i_num;
        end else if (r_busy) begin
            // shift in one numerator bit, subtract where it fits
            n_rem = fits ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
            n_quo = {r_quo[NW-2:0], fits};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[src/rvs_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvs_datapath
// Run statistics, configuration registers, averaging and report register.
// ----------------------------------------------------------------------------
module rvs_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rvs_pkg::t_dp_cmd                    i_cmd,
    output rvs_pkg::t_dp_stat                   o_stat,
    input  logic                                i_cfg_we,
    input  logic [rvs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rvs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [rvs_pkg::OP_W-1:0]            i_operation,
    input  logic [rvs_pkg::TIME_W-1:0]          i_time_ms,
    input  logic signed [rvs_pkg::ACC_W-1:0]    i_accel_vertical,
    input  logic                                i_noise_valid,
    input  logic [rvs_pkg::NOISE_W-1:0]         i_noise_level,
    input  logic signed [rvs_pkg::TEMP_W-1:0]   i_temperature,
    input  logic [rvs_pkg::HUMI_W-1:0]          i_humidity,
    output logic [rvs_pkg::ACC_W-1:0]           o_peak_deviation,
    output logic [rvs_pkg::ACC_W-1:0]           o_peak_jerk,
    output logic [rvs_pkg::TIME_W-1:0]          o_longest_shock_ms,
    output logic [rvs_pkg::NOISE_W-1:0]         o_mean_noise,
    output logic signed [rvs_pkg::TEMP_W-1:0]   o_mean_temperature,
    output logic [rvs_pkg::HUMI_W-1:0]          o_mean_humidity
);

    localparam int AW  = rvs_pkg::ACC_W;
    localparam int TW  = rvs_pkg::TIME_W;
    localparam int CW  = rvs_pkg::CNT_W;
    localparam int NSW = rvs_pkg::NOISE_SUM_W;
    localparam int HSW = rvs_pkg::HUMI_SUM_W;
    localparam int TSW = rvs_pkg::TEMP_SUM_W;
    localparam int MW  = rvs_pkg::MAG_W;
    localparam int NUW = rvs_pkg::DIV_NUM_W;
    localparam int DEW = rvs_pkg::DIV_DEN_W;

    // captured item
    rvs_pkg::t_op                   r_op;
    logic [TW-1:0]                  r_time;
    logic [AW-1:0]                  r_accel;
    logic                           r_nvalid;
    logic [rvs_pkg::NOISE_W-1:0]    r_noise;
    logic [rvs_pkg::TEMP_W-1:0]     r_temp;
    logic [rvs_pkg::HUMI_W-1:0]     r_humi;

    // configuration
    logic [rvs_pkg::THR_W-1:0]      r_thr;
    logic [rvs_pkg::TEMP_W-1:0]     r_def_temp;
    logic [rvs_pkg::HUMI_W-1:0]     r_def_humi;

    // run statistics
    logic            r_collecting, n_collecting;
    logic [AW-1:0]   r_base, n_base;
    logic [AW-1:0]   r_prev, n_prev;
    logic            r_have_prev, n_have_prev;
    logic [AW-1:0]   r_max_dev, n_max_dev;
    logic [AW-1:0]   r_max_chg, n_max_chg;
    logic            r_shock_act, n_shock_act;
    logic [TW-1:0]   r_shock_begin, n_shock_begin;
    logic [TW-1:0]   r_max_shock, n_max_shock;
    logic [NSW-1:0]  r_noise_total, n_noise_total;
    logic [CW-1:0]   r_noise_cnt, n_noise_cnt;
    logic [TSW-1:0]  r_temp_total, n_temp_total;
    logic [HSW-1:0]  r_humi_total, n_humi_total;
    logic [CW-1:0]   r_env_cnt, n_env_cnt;

    // averages of the latest stop, then the report register
    logic [rvs_pkg::NOISE_W-1:0]    r_mean_noise;
    logic [rvs_pkg::TEMP_W-1:0]     r_mean_temp;
    logic [rvs_pkg::HUMI_W-1:0]     r_mean_humi;
    logic [AW-1:0]                  r_out_dev;
    logic [AW-1:0]                  r_out_chg;
    logic [TW-1:0]                  r_out_shock;
    logic [rvs_pkg::NOISE_W-1:0]    r_out_noise;
    logic [rvs_pkg::TEMP_W-1:0]     r_out_temp;
    logic [rvs_pkg::HUMI_W-1:0]     r_out_humi;

    logic [AW:0]       dev_diff, chg_diff;
    logic [AW-1:0]     dev_abs, chg_abs;
    logic [TW-1:0]     shock_len;
    logic              temp_neg;
    logic [MW-1:0]     temp_mag;
    logic [MW-1:0]     div_mag;
    logic [CW-1:0]     div_cnt;
    logic [NUW-1:0]    div_num;
    logic [DEW-1:0]    div_den;
    logic              div_done;
    logic [NUW-1:0]    div_quo;
    logic [rvs_pkg::TEMP_W-1:0] quo_temp;

    // absolute differences of 16 bit signed values fit 16 bits unsigned
    assign dev_diff  = {r_accel[AW-1], r_accel} - {r_base[AW-1], r_base};
    assign chg_diff  = {r_accel[AW-1], r_accel} - {r_prev[AW-1], r_prev};
    assign dev_abs   = dev_diff[AW] ? AW'(~dev_diff + 1'b1) : dev_diff[AW-1:0];
    assign chg_abs   = chg_diff[AW] ? AW'(~chg_diff + 1'b1) : chg_diff[AW-1:0];
    assign shock_len = r_time - r_shock_begin;

    always_comb begin
        n_collecting  = r_collecting;
        n_base        = r_base;
        n_prev        = r_prev;
        n_have_prev   = r_have_prev;
        n_max_dev     = r_max_dev;
        n_max_chg     = r_max_chg;
        n_shock_act   = r_shock_act;
        n_shock_begin = r_shock_begin;
        n_max_shock   = r_max_shock;
        n_noise_total = r_noise_total;
        n_noise_cnt   = r_noise_cnt;
        n_temp_total  = r_temp_total;
        n_humi_total  = r_humi_total;
        n_env_cnt     = r_env_cnt;
        if (i_cmd.apply) begin
            case (r_op)
                rvs_pkg::OP_START: begin
                    n_collecting  = 1'b1;
                    n_base        = r_accel;
                    n_prev        = '0;
                    n_have_prev   = 1'b0;
                    n_max_dev     = '0;
                    n_max_chg     = '0;
                    n_shock_act   = 1'b0;
                    n_shock_begin = '0;
                    n_max_shock   = '0;
                    n_noise_total = '0;
                    n_noise_cnt   = '0;
                    n_temp_total  = '0;
                    n_humi_total  = '0;
                    n_env_cnt     = '0;
                end
                rvs_pkg::OP_SAMPLE: begin
                    if (r_collecting) begin
                        if (dev_abs > r_max_dev) begin
                            n_max_dev = dev_abs;
                        end
                        if (r_have_prev && (chg_abs > r_max_chg)) begin
                            n_max_chg = chg_abs;
                        end
                        n_prev      = r_accel;
                        n_have_prev = 1'b1;
                        if (dev_abs > r_thr) begin
                            if (!r_shock_act) begin
                                n_shock_act   = 1'b1;
                                n_shock_begin = r_time;
                            end
                        end else if (r_shock_act) begin
                            n_shock_act = 1'b0;
                            if (shock_len > r_max_shock) begin
                                n_max_shock = shock_len;
                            end
                        end
                        if (r_nvalid && (r_noise_cnt != rvs_pkg::COUNT_MAX)) begin
                            n_noise_total = r_noise_total + NSW'(r_noise);
                            n_noise_cnt   = r_noise_cnt + 1'b1;
                        end
                        if (r_env_cnt != rvs_pkg::COUNT_MAX) begin
                            n_temp_total = r_temp_total + TSW'(signed'(r_temp));
                            n_humi_total = r_humi_total + HSW'(r_humi);
                            n_env_cnt    = r_env_cnt + 1'b1;
                        end
                    end
                end
                rvs_pkg::OP_STOP: begin
                    n_collecting = 1'b0;
                    if (r_shock_act) begin
                        n_shock_act = 1'b0;
                        if (shock_len > r_max_shock) begin
                            n_max_shock = shock_len;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // divider operand selection
    assign temp_neg = r_temp_total[TSW-1];
    assign temp_mag = temp_neg ? MW'(~r_temp_total + 1'b1) : MW'(r_temp_total);

    always_comb begin
        case (i_cmd.div_sel)
            rvs_pkg::DIV_NOISE: begin
                div_mag = MW'(r_noise_total);
                div_cnt = r_noise_cnt;
            end
            rvs_pkg::DIV_TEMP: begin
                div_mag = temp_mag;
                div_cnt = r_env_cnt;
            end
            rvs_pkg::DIV_HUMI: begin
                div_mag = MW'(r_humi_total);
                div_cnt = r_env_cnt;
            end
            default: begin
                div_mag = '0;
                div_cnt = '0;
            end
        endcase
    end

    assign div_num = {div_mag, 1'b0} + NUW'(div_cnt);
    assign div_den = {div_cnt, 1'b0};

    rvs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign quo_temp = div_quo[rvs_pkg::TEMP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr         <= rvs_pkg::THRESHOLD_RESET;
            r_def_temp    <= rvs_pkg::DEFAULT_TEMP_RESET;
            r_def_humi    <= rvs_pkg::DEFAULT_HUMI_RESET;
            r_collecting  <= 1'b0;
            r_base        <= '0;
            r_prev        <= '0;
            r_have_prev   <= 1'b0;
            r_max_dev     <= '0;
            r_max_chg     <= '0;
            r_shock_act   <= 1'b0;
            r_shock_begin <= '0;
            r_max_shock   <= '0;
            r_noise_total <= '0;
            r_noise_cnt   <= '0;
            r_temp_total  <= '0;
            r_humi_total  <= '0;
            r_env_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rvs_pkg::CFG_THRESHOLD:    r_thr      <= i_cfg_data;
                    rvs_pkg::CFG_DEFAULT_TEMP: r_def_temp <= i_cfg_data[rvs_pkg::TEMP_W-1:0];
                    rvs_pkg::CFG_DEFAULT_HUMI: r_def_humi <= i_cfg_data[rvs_pkg::HUMI_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_collecting  <= n_collecting;
            r_base        <= n_base;
            r_prev        <= n_prev;
            r_have_prev   <= n_have_prev;
            r_max_dev     <= n_max_dev;
            r_max_chg     <= n_max_chg;
            r_shock_act   <= n_shock_act;
            r_shock_begin <= n_shock_begin;
            r_max_shock   <= n_max_shock;
            r_noise_total <= n_noise_total;
            r_noise_cnt   <= n_noise_cnt;
            r_temp_total  <= n_temp_total;
            r_humi_total  <= n_humi_total;
            r_env_cnt     <= n_env_cnt;
        end
    end

    // payload registers: item capture, averages, report
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_operation;
            r_time   <= i_time_ms;
            r_accel  <= i_accel_vertical;
            r_nvalid <= i_noise_valid;
            r_noise  <= i_noise_level;
            r_temp   <= i_temperature;
            r_humi   <= i_humidity;
        end
        if (i_cmd.save_quo) begin
            case (i_cmd.div_sel)
                rvs_pkg::DIV_NOISE: begin
                    r_mean_noise <= (r_noise_cnt == '0) ? '0 :
                                    div_quo[rvs_pkg::NOISE_W-1:0];
                end
                rvs_pkg::DIV_TEMP: begin
                    if (r_env_cnt == '0) begin
                        r_mean_temp <= r_def_temp;
                    end else begin
                        r_mean_temp <= temp_neg ? (~quo_temp + 1'b1) : quo_temp;
                    end
                end
                rvs_pkg::DIV_HUMI: begin
                    r_mean_humi <= (r_env_cnt == '0) ? r_def_humi :
                                   div_quo[rvs_pkg::HUMI_W-1:0];
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.load_out) begin
            r_out_dev   <= r_max_dev;
            r_out_chg   <= r_max_chg;
            r_out_shock <= r_max_shock;
            r_out_noise <= r_mean_noise;
            r_out_temp  <= r_mean_temp;
            r_out_humi  <= r_mean_humi;
        end
    end

    assign o_stat.op       = r_op;
    assign o_stat.div_done = div_done;

    assign o_peak_deviation   = r_out_dev;
    assign o_peak_jerk        = r_out_chg;
    assign o_longest_shock_ms = r_out_shock;
    assign o_mean_noise       = r_out_noise;
    assign o_mean_temperature = r_out_temp;
    assign o_mean_humidity    = r_out_humi;

endmodule

[src/rvs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvs_ctrl
// Sequencer: accept, apply, three averaging divisions, report handoff.
// ----------------------------------------------------------------------------
module rvs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rvs_pkg::t_dp_stat i_stat,
    output rvs_pkg::t_dp_cmd  o_cmd
);

    rvs_pkg::t_state   r_state, n_state;
    rvs_pkg::t_div_sel r_sel, n_sel;
    logic              r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.div_sel = r_sel;
        case (r_state)
            rvs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = rvs_pkg::ST_APPLY;
                end
            end
            rvs_pkg::ST_APPLY: begin
                o_cmd.apply = 1'b1;
                if (i_stat.op == rvs_pkg::OP_STOP) begin
                    n_sel   = rvs_pkg::DIV_NOISE;
                    n_state = rvs_pkg::ST_DIV_START;
                end else begin
                    n_state = rvs_pkg::ST_IDLE;
                end
            end
            rvs_pkg::ST_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = rvs_pkg::ST_DIV_WAIT;
            end
            rvs_pkg::ST_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.save_quo = 1'b1;
                    case (r_sel)
                        rvs_pkg::DIV_NOISE: begin
                            n_sel   = rvs_pkg::DIV_TEMP;
                            n_state = rvs_pkg::ST_DIV_START;
                        end
                        rvs_pkg::DIV_TEMP: begin
                            n_sel   = rvs_pkg::DIV_HUMI;
                            n_state = rvs_pkg::ST_DIV_START;
                        end
                        default: begin
                            n_state = rvs_pkg::ST_REPORT;
                        end
                    endcase
                end
            end
            rvs_pkg::ST_REPORT: begin
                // hold until the report register is free or being drained
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = rvs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rvs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rvs_pkg::ST_IDLE;
            r_sel       <= rvs_pkg::DIV_NOISE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[src/ride_vibration_statistics_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ride_vibration_statistics_unit
// Per-run ride statistics: peaks, longest shock and environment averages.
// ----------------------------------------------------------------------------
// Usage:
//   i_item is a valid/ready input channel. Each item is a sample, a run start
//   or a run stop. Only a stop produces a report item on o_result.
//   Configuration (shock threshold, default temperature, default humidity)
//   is written through i_cfg_we / i_cfg_index / i_cfg_data while idle.
// Timing:
//   One item at a time. A start or sample passes through capture and apply,
//   and ready returns after the apply step. A stop passes through capture,
//   apply, then three rounding divisions on one shared restoring divider
//   (34 quotient bits, one per cycle), then the report load. The report
//   appears on o_result in the cycle after the load.
// Backpressure:
//   The report sits in an output register; new items are accepted while it
//   waits. A following stop holds in its report step until the old report
//   is taken.
// Reset:
//   Synchronous, active low. Clears the run and its statistics and restores
//   the configuration defaults (threshold 128, 400, 800).
// ----------------------------------------------------------------------------
module ride_vibration_statistics_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rvs_in_if.sink                            i_item,
    rvs_out_if.source                         o_result,
    input  logic                              i_cfg_we,
    input  logic [rvs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rvs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    rvs_pkg::t_dp_cmd  dp_cmd;
    rvs_pkg::t_dp_stat dp_stat;
    logic              in_ready;
    logic              out_valid;

    // sequencer: owns the handshakes and the report valid flag
    rvs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // statistics, configuration, divider and report register
    rvs_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_stat             (dp_stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_operation        (i_item.operation),
        .i_time_ms          (i_item.time_ms),
        .i_accel_vertical   (i_item.accel_vertical),
        .i_noise_valid      (i_item.noise_valid),
        .i_noise_level      (i_item.noise_level),
        .i_temperature      (i_item.temperature),
        .i_humidity         (i_item.humidity),
        .o_peak_deviation   (o_result.peak_deviation),
        .o_peak_jerk        (o_result.peak_jerk),
        .o_longest_shock_ms (o_result.longest_shock_ms),
        .o_mean_noise       (o_result.mean_noise),
        .o_mean_temperature (o_result.mean_temperature),
        .o_mean_humidity    (o_result.mean_humidity)
    );

    assign i_item.ready   = in_ready;
    assign o_result.valid = out_valid;

endmodule
